/* design/pptv_pkg.sv */
// Shared types, constants and register indexes for the perspective projection block.
// No dependencies.
`default_nettype none
package pptv_pkg;
  localparam int COEFF_FRAC_BITS = 14;
  localparam int RECIP_BITS      = 24;

  localparam logic [2:0] REG_ROW_X  = 3'd0;
  localparam logic [2:0] REG_ROW_Y  = 3'd1;
  localparam logic [2:0] REG_ROW_W  = 3'd2;
  localparam logic [2:0] REG_SIZE   = 3'd3;
  localparam logic [2:0] REG_ORIGIN = 3'd4;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
  } in_t;

  typedef struct packed {
    logic               visible;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
  } out_t;
endpackage
`default_nettype wire

/* design/pptv_divider.sv */
// Pipelined restoring divider: one quotient bit per stage, one request per cycle.
// Depends on nothing; carries sideband data alongside the quotient.
`default_nettype none
module pptv_divider #(
  parameter int NUM_W  = 48,
  parameter int DEN_W  = 40,
  parameter int SIDE_W = 8
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  input  wire [NUM_W-1:0]   in_num,
  input  wire [DEN_W-1:0]   in_den,
  input  wire [SIDE_W-1:0]  in_side,
  output logic              out_valid,
  output logic [NUM_W-1:0]  out_quo,
  output logic [SIDE_W-1:0] out_side
);
  logic              vld_c  [NUM_W+1];
  logic [NUM_W-1:0]  num_c  [NUM_W+1];
  logic [DEN_W:0]    rem_c  [NUM_W+1];
  logic [DEN_W-1:0]  den_c  [NUM_W+1];
  logic [SIDE_W-1:0] side_c [NUM_W+1];

  assign vld_c[0]  = in_valid;
  assign num_c[0]  = in_num;
  assign rem_c[0]  = '0;
  assign den_c[0]  = in_den;
  assign side_c[0] = in_side;

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic              vld_r;
    logic [NUM_W-1:0]  num_r;
    logic [DEN_W:0]    rem_r;
    logic [DEN_W-1:0]  den_r;
    logic [SIDE_W-1:0] side_r;
    logic [DEN_W+1:0]  trial;
    logic [DEN_W:0]    rem_nxt;
    logic [NUM_W-1:0]  num_nxt;
    always_comb begin
      trial = {rem_c[s], num_c[s][NUM_W-1-s]} - {2'b00, den_c[s]};
      num_nxt = num_c[s];
      num_nxt[NUM_W-1-s] = ~trial[DEN_W+1];
      if (trial[DEN_W+1]) rem_nxt = {rem_c[s][DEN_W-1:0], num_c[s][NUM_W-1-s]};
      else rem_nxt = trial[DEN_W:0];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r <= 1'b0;
      else vld_r <= vld_c[s];
      rem_r  <= rem_nxt;
      den_r  <= den_c[s];
      side_r <= side_c[s];
      num_r  <= num_nxt;
    end
    assign vld_c[s+1]  = vld_r;
    assign num_c[s+1]  = num_r;
    assign rem_c[s+1]  = rem_r;
    assign den_c[s+1]  = den_r;
    assign side_c[s+1] = side_r;
  end

  assign out_valid = vld_c[NUM_W];
  assign out_quo   = num_c[NUM_W];
  assign out_side  = side_c[NUM_W];
endmodule
`default_nettype wire

/* design/perspective_project_to_viewport.sv */
// Top level: matrix rows, w cull test, pipelined reciprocal, normalize, viewport map.
// Depends on pptv_pkg and pptv_divider.
//
// channel | ports                      | handshake
// input   | in_data                    | start & !busy
// result  | out_data                   | out_strobe, one cycle
// config  | cfg_index, cfg_data        | cfg_valid & cfg_ready
//
// One request per cycle; busy is low outside reset. Each request passes through
// three front stages, one stage per reciprocal bit (RECIP_BITS+COEFF_FRAC_BITS+1) and
// four back stages before its result is shown on out_data with out_strobe.
// Reset clears the valid bits and the configuration registers.
// Results cannot be stalled; the pipeline never holds.
`default_nettype none
module perspective_project_to_viewport #(
  parameter int COEFF_FRAC_BITS = pptv_pkg::COEFF_FRAC_BITS,
  parameter int RECIP_BITS      = pptv_pkg::RECIP_BITS
) (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            start,
  output logic           busy,
  input  wire pptv_pkg::in_t in_data,
  output logic           out_strobe,
  output pptv_pkg::out_t out_data,
  input  wire            cfg_valid,
  output logic           cfg_ready,
  input  wire [2:0]      cfg_index,
  input  wire [63:0]     cfg_data
);
  localparam int F     = COEFF_FRAC_BITS;
  localparam int ACC_W = 36 + F;
  localparam int NUM_W = F + RECIP_BITS + 1;
  localparam int RCP_W = NUM_W;
  localparam int SIDE_W = 2 * ACC_W;
  localparam int NDC_W = F + 20;
  localparam logic [63:0] LIM = 64'd1 << (F + 18);

  logic [63:0] row_x_r, row_y_r, row_w_r;
  logic [31:0] size_r, origin_r;

  assign busy = !rst_n;
  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_x_r <= '0; row_y_r <= '0; row_w_r <= '0; size_r <= '0; origin_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        pptv_pkg::REG_ROW_X:  row_x_r  <= cfg_data;
        pptv_pkg::REG_ROW_Y:  row_y_r  <= cfg_data;
        pptv_pkg::REG_ROW_W:  row_w_r  <= cfg_data;
        pptv_pkg::REG_SIZE:   size_r   <= cfg_data[31:0];
        pptv_pkg::REG_ORIGIN: origin_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // stage 1: nine products
  logic        s1_v_r;
  logic signed [31:0] px_r [3], py_r [3], pz_r [3];
  logic signed [15:0] off_r [3];
  logic [63:0] rows [3];
  assign rows[0] = row_x_r;
  assign rows[1] = row_y_r;
  assign rows[2] = row_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else s1_v_r <= start;
    for (int r = 0; r < 3; r++) begin
      px_r[r]  <= $signed(rows[r][15:0])  * in_data.pos_x;
      py_r[r]  <= $signed(rows[r][31:16]) * in_data.pos_y;
      pz_r[r]  <= $signed(rows[r][47:32]) * in_data.pos_z;
      off_r[r] <= $signed(rows[r][63:48]);
    end
  end

  // stage 2: row sums
  logic s2_v_r;
  logic signed [ACC_W-1:0] acc_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else s2_v_r <= s1_v_r;
    for (int r = 0; r < 3; r++)
      acc_r[r] <= ACC_W'(px_r[r]) + ACC_W'(py_r[r]) + ACC_W'(pz_r[r])
                + (ACC_W'(off_r[r]) <<< F);
  end

  // stage 3: cull test
  logic s3_v_r, s3_vis_r;
  logic signed [ACC_W-1:0] s3_x_r, s3_y_r, s3_w_r;
  logic signed [ACC_W+7:0] w100;
  assign w100 = (ACC_W+8)'(acc_r[2]) * (ACC_W+8)'(100);
  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else s3_v_r <= s2_v_r;
    s3_vis_r <= !(w100 < ((ACC_W+8)'(1) <<< F));
    s3_x_r <= acc_r[0];
    s3_y_r <= acc_r[1];
    s3_w_r <= acc_r[2];
  end

  logic [NUM_W-1:0] div_num;
  logic [ACC_W-1:0] div_den;
  assign div_num = NUM_W'(1) << (F + RECIP_BITS);
  assign div_den = s3_vis_r ? s3_w_r : ACC_W'(1);

  logic              dv_v;
  logic [RCP_W-1:0]  recip;
  logic [SIDE_W:0]   dv_side;
  pptv_divider #(.NUM_W(NUM_W), .DEN_W(ACC_W), .SIDE_W(SIDE_W+1)) u_div (
    .clk, .rst_n, .in_valid(s3_v_r), .in_num(div_num), .in_den(div_den),
    .in_side({s3_vis_r, s3_x_r, s3_y_r}),
    .out_valid(dv_v), .out_quo(recip), .out_side(dv_side)
  );

  // stage 4: magnitudes times reciprocal (two partial halves)
  logic s4_v_r, s4_vis_r, s4_nx_r, s4_ny_r;
  logic [63:0] mx_hi_r, mx_lo_r, my_hi_r, my_lo_r;
  logic signed [ACC_W-1:0] dx, dy;
  logic [ACC_W-1:0] mx, my;
  assign dx = dv_side[SIDE_W-1:ACC_W];
  assign dy = dv_side[ACC_W-1:0];
  assign mx = dx[ACC_W-1] ? ACC_W'(-dx) : ACC_W'(dx);
  assign my = dy[ACC_W-1] ? ACC_W'(-dy) : ACC_W'(dy);
  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else s4_v_r <= dv_v;
    s4_vis_r <= dv_side[SIDE_W];
    s4_nx_r <= dx[ACC_W-1];
    s4_ny_r <= dy[ACC_W-1];
    mx_hi_r <= 64'(mx >> 18) * 64'(recip);
    mx_lo_r <= 64'(mx[17:0]) * 64'(recip);
    my_hi_r <= 64'(my >> 18) * 64'(recip);
    my_lo_r <= 64'(my[17:0]) * 64'(recip);
  end

  function automatic logic [63:0] combine(input logic [63:0] hi, input logic [63:0] lo);
    logic [63:0] hq, hr, q;
    hq = hi >> RECIP_BITS;
    hr = hi & ((64'd1 << RECIP_BITS) - 64'd1);
    if (hq >= (64'd1 << F)) q = LIM;
    else begin
      q = (hq << 18) + (((hr << 18) + lo) >> RECIP_BITS);
      if (q > LIM) q = LIM;
    end
    return q;
  endfunction

  // stage 5: normalized values
  logic s5_v_r, s5_vis_r;
  logic signed [NDC_W-1:0] nx_r, ny_r;
  logic [63:0] qx, qy;
  assign qx = combine(mx_hi_r, mx_lo_r);
  assign qy = combine(my_hi_r, my_lo_r);
  always_ff @(posedge clk) begin
    if (!rst_n) s5_v_r <= 1'b0;
    else s5_v_r <= s4_v_r;
    s5_vis_r <= s4_vis_r;
    nx_r <= s4_nx_r ? -$signed(NDC_W'(qx)) : $signed(NDC_W'(qx));
    ny_r <= s4_ny_r ? -$signed(NDC_W'(qy)) : $signed(NDC_W'(qy));
  end

  // stage 6: scale by extent
  localparam int V_W = NDC_W + 20;
  logic s6_v_r, s6_vis_r;
  logic signed [V_W-1:0] sx_r, sy_r, bx_r, by_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s6_v_r <= 1'b0;
    else s6_v_r <= s5_v_r;
    s6_vis_r <= s5_vis_r;
    sx_r <= V_W'(nx_r) * $signed({1'b0, size_r[15:0]}) + (V_W'(1) <<< F);
    sy_r <= V_W'(ny_r) * $signed({1'b0, size_r[31:16]}) + (V_W'(1) <<< F);
    bx_r <= (V_W'($signed({2'b0, size_r[15:1]})) + V_W'($signed(origin_r[15:0]))) <<< (F+1);
    by_r <= (V_W'($signed({2'b0, size_r[31:17]})) + V_W'($signed(origin_r[31:16]))) <<< (F+1);
  end

  function automatic logic [15:0] to_pixel(input logic signed [V_W-1:0] v);
    logic signed [V_W-1:0] p;
    p = v >>> (F + 1);
    if (v[V_W-1] && (v[F:0] != '0)) p = p + V_W'(1);
    if (p > V_W'(32767)) return 16'h7fff;
    if (p < -V_W'(32768)) return 16'h8000;
    return p[15:0];
  endfunction

  // stage 7: sum and saturate
  logic s7_v_r;
  pptv_pkg::out_t res_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s7_v_r <= 1'b0;
    else s7_v_r <= s6_v_r;
    res_r.visible  <= s6_vis_r;
    res_r.screen_x <= s6_vis_r ? to_pixel(bx_r + sx_r) : '0;
    res_r.screen_y <= s6_vis_r ? to_pixel(by_r - sy_r) : '0;
  end

  assign out_strobe = s7_v_r;
  assign out_data   = res_r;
endmodule
`default_nettype wire

/* design/pptv_checker.sv */
// Port-level checks for perspective_project_to_viewport, bound to the top level.
// Depends on pptv_pkg.
`default_nettype none
module pptv_checker (
  input wire clk,
  input wire rst_n,
  input wire busy,
  input wire out_strobe,
  input wire pptv_pkg::out_t out_data,
  input wire cfg_ready
);
  a_busy: assert property (@(posedge clk) rst_n |-> !busy) else $error("busy");
  a_cull: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_data.visible |-> out_data.screen_x == 16'sd0 &&
    out_data.screen_y == 16'sd0) else $error("culled point not zero");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("strobe after reset");
  a_cfg: assert property (@(posedge clk) rst_n |-> cfg_ready)
    else $error("cfg stall");
endmodule

bind perspective_project_to_viewport pptv_checker u_chk (
  .clk, .rst_n, .busy, .out_strobe, .out_data, .cfg_ready
);
`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for perspective_project_to_viewport: directed table, then random points.
// Depends on pptv_pkg and the design sources; predicts each pixel from its own fixed-point model.
`default_nettype none
module tb;
  localparam int LATENCY   = pptv_pkg::RECIP_BITS + pptv_pkg::COEFF_FRAC_BITS + 8;
  localparam int MAX_CYCLE = 1000000;
  localparam int N_RANDOM  = 2000;
  localparam int N_DIR     = 12;
  localparam int FB        = pptv_pkg::COEFF_FRAC_BITS;
  localparam int RB        = pptv_pkg::RECIP_BITS;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  pptv_pkg::in_t in_data = '0;
  logic out_strobe;
  pptv_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = pptv_pkg::REG_ROW_X;
  logic [63:0] cfg_data = '0;

  logic [63:0] row_x, row_y, row_w;
  logic [31:0] vp_size, vp_origin;
  pptv_pkg::out_t pixel_q[$];
  int errors = 0;
  int cycles = 0;

  perspective_project_to_viewport dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLE) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pixel_q.size() == 0) begin
        report("unexpected result", longint'(0), longint'(0));
      end else begin
        pptv_pkg::out_t e;
        e = pixel_q.pop_front();
        if (out_data.visible !== e.visible)
          report("visible", longint'(out_data.visible), longint'(e.visible));
        if (out_data.screen_x !== e.screen_x)
          report("screen_x", longint'(out_data.screen_x), longint'(e.screen_x));
        if (out_data.screen_y !== e.screen_y)
          report("screen_y", longint'(out_data.screen_y), longint'(e.screen_y));
      end
    end
  end

  function automatic longint row_dot(logic [63:0] r, pptv_pkg::in_t p);
    longint s;
    s = longint'($signed(r[15:0])) * p.pos_x + longint'($signed(r[31:16])) * p.pos_y
      + longint'($signed(r[47:32])) * p.pos_z;
    return s + (longint'($signed(r[63:48])) <<< FB);
  endfunction

  function automatic longint ndc_scale(longint acc, logic [63:0] recip);
    logic [63:0] mag, lim, hi, lo, hq, hr, q;
    mag = acc < 0 ? -acc : acc;
    lim = 64'd1 << (FB + 18);
    hi = (mag >> 18) * recip;
    lo = (mag & 64'h3FFFF) * recip;
    hq = hi >> RB;
    hr = hi & ((64'd1 << RB) - 1);
    if (hq >= (64'd1 << FB)) q = lim;
    else begin
      q = (hq << 18) + (((hr << 18) + lo) >> RB);
      if (q > lim) q = lim;
    end
    return acc < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [15:0] clamp_pixel(longint v);
    longint p;
    p = v / (longint'(1) <<< (FB + 1));
    if (p > 32767) p = 32767;
    if (p < -32768) p = -32768;
    return p[15:0];
  endfunction

  function automatic pptv_pkg::out_t project_point(pptv_pkg::in_t p);
    pptv_pkg::out_t r;
    longint xa, ya, wa, one, nx, ny, w, h, l, t;
    logic [63:0] recip;
    xa = row_dot(row_x, p);
    ya = row_dot(row_y, p);
    wa = row_dot(row_w, p);
    one = longint'(1) <<< FB;
    r = '0;
    if (wa * 100 < one) return r;
    recip = (64'd1 << (FB + RB)) / 64'(wa);
    nx = ndc_scale(xa, recip);
    ny = ndc_scale(ya, recip);
    w = longint'(vp_size[15:0]);
    h = longint'(vp_size[31:16]);
    l = longint'($signed(vp_origin[15:0]));
    t = longint'($signed(vp_origin[31:16]));
    r.visible = 1'b1;
    r.screen_x = clamp_pixel((w / 2 + l) * 2 * one + nx * w + one);
    r.screen_y = clamp_pixel((h / 2 + t) * 2 * one - (ny * h + one));
    return r;
  endfunction

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      pptv_pkg::REG_ROW_X:  row_x = val;
      pptv_pkg::REG_ROW_Y:  row_y = val;
      pptv_pkg::REG_ROW_W:  row_w = val;
      pptv_pkg::REG_SIZE:   vp_size = val[31:0];
      pptv_pkg::REG_ORIGIN: vp_origin = val[31:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic send_point(input pptv_pkg::in_t p, input bit gaps);
    start <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    pixel_q.push_back(project_point(p));
    if (gaps && $urandom_range(0, 1)) idle_gap();
  endtask

  function automatic logic [63:0] rand_row(bit w_row);
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    if ($urandom_range(0, 2) != 0) begin
      r[15:0] = 16'($signed($urandom_range(0, 8191)) - 4096);
      r[31:16] = 16'($signed($urandom_range(0, 8191)) - 4096);
      r[47:32] = 16'($signed($urandom_range(0, 8191)) - 4096);
      r[63:48] = w_row ? 16'($urandom_range(0, 400)) : 16'($urandom_range(0, 4000) - 2000);
    end
    return r;
  endfunction

  function automatic pptv_pkg::in_t rand_point();
    pptv_pkg::in_t p;
    p = pptv_pkg::in_t'(48'({$urandom(), $urandom()}));
    if ($urandom_range(0, 2) != 0) begin
      p.pos_x = 16'($urandom_range(0, 200) - 100);
      p.pos_y = 16'($urandom_range(0, 200) - 100);
      p.pos_z = 16'($urandom_range(0, 200) - 100);
    end
    return p;
  endfunction

  typedef struct {
    pptv_pkg::in_t  pt;
    bit             known;
    pptv_pkg::out_t want;
  } dir_row_t;

  dir_row_t dir_tab[N_DIR];

  initial begin
    pptv_pkg::in_t p;
    pptv_pkg::out_t pr;
    row_x = '0; row_y = '0; row_w = '0; vp_size = '0; vp_origin = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir_tab[0] = '{'{16'sd0, 16'sd0, 16'sd0}, 1'b1, '0};
    dir_tab[1] = '{'{16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b1, '0};
    dir_tab[2] = '{'{16'h8000, 16'h8000, 16'h8000}, 1'b1, '0};
    for (int i = 0; i < 3; i++) send_point(dir_tab[i].pt, 1'b0);
    start <= 1'b0;
    drain();

    write_reg(pptv_pkg::REG_ROW_X, {16'sd0, 16'sd0, 16'sd0, 16'sd16384});
    write_reg(pptv_pkg::REG_ROW_Y, {16'sd0, 16'sd0, 16'sd16384, 16'sd0});
    write_reg(pptv_pkg::REG_ROW_W, {16'sd1, 16'sd0, 16'sd0, 16'sd0});
    write_reg(pptv_pkg::REG_SIZE, 64'({16'd480, 16'd640}));
    write_reg(pptv_pkg::REG_ORIGIN, 64'({16'sd0, 16'sd0}));
    dir_tab[3] = '{'{16'sd0, 16'sd0, 16'sd0}, 1'b1, '{1'b1, 16'sd320, 16'sd239}};
    dir_tab[4] = '{'{16'sd1, 16'sd1, 16'sd0}, 1'b0, '0};
    dir_tab[5] = '{'{16'h7FFF, 16'h8000, 16'sd0}, 1'b1, '{1'b1, 16'h7FFF, 16'h7FFF}};
    dir_tab[6] = '{'{16'h8000, 16'h7FFF, 16'h7FFF}, 1'b1, '{1'b1, 16'h8000, 16'h8000}};
    dir_tab[7] = '{'{16'sd1, 16'sd0, 16'sd0}, 1'b0, '0};
    dir_tab[8] = '{'{16'sd0, 16'sd0, 16'h7FFF}, 1'b0, '0};
    dir_tab[9] = '{'{16'sd0, 16'sd0, 16'h8000}, 1'b1, '0};
    dir_tab[10] = '{'{16'sd5, 16'sd1, 16'sd0}, 1'b0, '0};
    dir_tab[11] = '{'{16'h8000, 16'sd3, 16'sd0}, 1'b0, '0};
    write_reg(pptv_pkg::REG_ROW_W, {16'sd1, 16'sd0, 16'sd0, 16'sd0});
    for (int i = 3; i < 9; i++) begin
      p = dir_tab[i].pt;
      pr = project_point(p);
      if (dir_tab[i].known && pr !== dir_tab[i].want)
        report("directed table", longint'(i), longint'(0));
      send_point(p, 1'b1);
    end
    start <= 1'b0;
    drain();

    write_reg(pptv_pkg::REG_ROW_W, {16'sd0, 16'sd100, 16'sd0, 16'sd0});
    write_reg(pptv_pkg::REG_SIZE, 64'(32'd0));
    write_reg(pptv_pkg::REG_ORIGIN, 64'({16'h8000, 16'h7FFF}));
    for (int i = 9; i < N_DIR; i++) begin
      p = dir_tab[i].pt;
      pr = project_point(p);
      if (dir_tab[i].known && pr !== dir_tab[i].want)
        report("directed table", longint'(i), longint'(0));
      send_point(p, 1'b1);
    end
    start <= 1'b0;
    drain();
    write_reg(pptv_pkg::REG_SIZE, 64'(32'hFFFF_FFFF));
    write_reg(pptv_pkg::REG_ORIGIN, 64'(32'hFFFF_FFFF));
    write_reg(pptv_pkg::REG_ROW_X, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(pptv_pkg::REG_ROW_Y, 64'h8000_8000_8000_8000);
    write_reg(pptv_pkg::REG_ROW_W, 64'h7FFF_7FFF_7FFF_7FFF);
    for (int i = 0; i < 3; i++) send_point(dir_tab[i].pt, 1'b0);
    start <= 1'b0;
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(pptv_pkg::REG_ROW_X, rand_row(1'b0));
      write_reg(pptv_pkg::REG_ROW_Y, rand_row(1'b0));
      write_reg(pptv_pkg::REG_ROW_W, rand_row(1'b1));
      write_reg(pptv_pkg::REG_SIZE,
                64'((ph == 0) ? 32'h0 : (ph == 1) ? 32'hFFFF_FFFF : $urandom()));
      write_reg(pptv_pkg::REG_ORIGIN, 64'($urandom_range(0, 1) ? $urandom()
                : {16'($urandom_range(0, 200)), 16'($urandom_range(0, 200))}));
      for (int i = 0; i < N_RANDOM / 8; i++) begin
        send_point(rand_point(), ph > 1);
        if (i == 100) begin
          start <= 1'b0;
          while (pixel_q.size() != 0) @(posedge clk);
        end
      end
      start <= 1'b0;
      drain();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
design/pptv_pkg.sv
design/pptv_divider.sv
design/perspective_project_to_viewport.sv
design/pptv_checker.sv
dv/tb.sv
